[rtl/ccal_pkg.sv]
package ccal_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Configuration register indexes
  localparam logic CFG_WAKE_HOUR   = 1'b0;
  localparam logic CFG_WAKE_MINUTE = 1'b1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned S_DATA_W   = 48;
  localparam int unsigned M_DATA_W   = 48;

  localparam logic [15:0] YEAR_MIN        = 16'd2000;
  localparam logic [4:0]  HOURS_PER_DAY   = 5'd24;
  localparam logic [5:0]  MINS_PER_HOUR   = 6'd60;
  localparam logic [5:0]  SECS_PER_MIN    = 6'd60;
  localparam logic [2:0]  LAST_WEEKDAY    = 3'd6;
  localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
  localparam logic [3:0]  FEBRUARY        = 4'd2;
  localparam logic [4:0]  FEB_LEAP_DAYS   = 5'd29;
  localparam logic [4:0]  LONG_MONTH_DAYS = 5'd31;

  // Reset date: Saturday 1 January 2000, midnight
  localparam logic [15:0] RST_YEAR        = 16'd2000;
  localparam logic [3:0]  RST_MONTH       = 4'd1;
  localparam logic [4:0]  RST_MDAY        = 5'd1;
  localparam logic [2:0]  RST_WEEKDAY     = 3'd6;
  localparam logic [4:0]  RST_WAKE_HOUR   = 5'd0;
  localparam logic [5:0]  RST_WAKE_MINUTE = 6'd1;

  // ceil(2^21 / 25): exact quotient by 25 for every 16-bit year
  localparam logic [16:0] RECIP_25  = 17'd83887;
  localparam int unsigned RECIP_SHR = 21;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Gregorian leap rule; divisibility by 25 through a reciprocal multiply
  function automatic logic is_leap(input logic [15:0] year);
    logic [32:0] prod;
    logic [11:0] quot;
    logic [16:0] back;
    logic        div4;
    logic        div25;
    prod  = {17'd0, year} * {16'd0, RECIP_25};
    quot  = prod[32:RECIP_SHR];
    back  = {quot, 4'd0} + {1'b0, quot, 3'd0} + {5'd0, quot};
    div4  = (year[1:0] == 2'd0);
    div25 = (back == {1'b0, year});
    return (div25 && (year[3:0] == 4'd0)) || (div4 && !div25);
  endfunction

  // Month length; months outside 1..12 report a long month
  function automatic logic [4:0] days_in(input logic [15:0] year, input logic [3:0] month);
    logic [4:0] len;
    if ((month == 4'd0) || (month > MONTHS_PER_YEAR)) begin
      len = LONG_MONTH_DAYS;
    end else if ((month == FEBRUARY) && is_leap(year)) begin
      len = FEB_LEAP_DAYS;
    end else begin
      len = MONTH_LEN[month - 4'd1];
    end
    return len;
  endfunction

endpackage

[rtl/ccal_tick.sv]
module ccal_tick (
  input  ccal_pkg::cal_t cur_i,
  input  logic [4:0]     wake_hour_i,
  input  logic [5:0]     wake_minute_i,
  output ccal_pkg::cal_t nxt_o,
  output logic           fire_o
);

  logic       sec_wrap;
  logic       min_wrap;
  logic       hour_wrap;
  logic       day_wrap;
  logic       month_wrap;
  logic [4:0] month_days;

  assign month_days = ccal_pkg::days_in(cur_i.year, cur_i.month);
  assign sec_wrap   = (cur_i.second == ccal_pkg::SECS_PER_MIN - 6'd1);
  assign min_wrap   = sec_wrap && (cur_i.minute == ccal_pkg::MINS_PER_HOUR - 6'd1);
  assign hour_wrap  = min_wrap && (cur_i.hour == ccal_pkg::HOURS_PER_DAY - 5'd1);
  assign day_wrap   = hour_wrap && (cur_i.mday >= month_days);
  assign month_wrap = day_wrap && (cur_i.month >= ccal_pkg::MONTHS_PER_YEAR);

  always_comb begin
    nxt_o = cur_i;
    nxt_o.second = sec_wrap ? 6'd0 : cur_i.second + 6'd1;
    if (sec_wrap) begin
      nxt_o.minute = min_wrap ? 6'd0 : cur_i.minute + 6'd1;
    end
    if (min_wrap) begin
      nxt_o.hour = hour_wrap ? 5'd0 : cur_i.hour + 5'd1;
    end
    if (hour_wrap) begin
      nxt_o.weekday = (cur_i.weekday >= ccal_pkg::LAST_WEEKDAY) ? 3'd0 : cur_i.weekday + 3'd1;
      nxt_o.mday    = day_wrap ? 5'd1 : cur_i.mday + 5'd1;
    end
    if (day_wrap) begin
      nxt_o.month = month_wrap ? 4'd1 : cur_i.month + 4'd1;
    end
    if (month_wrap) begin
      nxt_o.year = cur_i.year + 16'd1;
    end
  end

  // Seconds of day reach the wake time exactly when (hour, minute) >= (wake hour, wake minute)
  assign fire_o = (nxt_o.hour > wake_hour_i) ||
                  ((nxt_o.hour == wake_hour_i) && (nxt_o.minute >= wake_minute_i));

endmodule

[rtl/ccal_load_chk.sv]
module ccal_load_chk (
  input  ccal_pkg::cal_t set_i,
  output logic           ok_o
);

  logic [4:0] month_days;

  assign month_days = ccal_pkg::days_in(set_i.year, set_i.month);

  assign ok_o = (set_i.year >= ccal_pkg::YEAR_MIN) &&
                (set_i.month != 4'd0) && (set_i.month <= ccal_pkg::MONTHS_PER_YEAR) &&
                (set_i.weekday <= ccal_pkg::LAST_WEEKDAY) &&
                (set_i.mday != 5'd0) && (set_i.mday <= month_days) &&
                (set_i.hour < ccal_pkg::HOURS_PER_DAY) &&
                (set_i.minute < ccal_pkg::MINS_PER_HOUR) &&
                (set_i.second < ccal_pkg::SECS_PER_MIN);

endmodule

[rtl/calendar_clock_with_alarm.sv]
// A result passes through the input register and then the result register.
// Throughput: one item per cycle unless the output stalls; calendar state updates per item.
// A full result register still accepts a new input; the input register holds it until taken.
// Reset (rst_ni low, asynchronous): Saturday 2000-01-01 00:00:00, alarm clear, time not synced,
// wake time 00:01, both pipeline stages empty.
module calendar_clock_with_alarm (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration writes
  input  logic                                cfg_we_i,
  input  logic [ccal_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ccal_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] set_year, [19:16] set_month, [24:20] set_mday, [27:25] set_weekday,
  // [32:28] set_hour, [38:33] set_minute, [44:39] set_second, [47:45] zero
  input  logic [ccal_pkg::S_DATA_W-1:0]       s_axis_tdata,
  // [1:0] op
  input  logic [ccal_pkg::OP_W-1:0]           s_axis_tuser,
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] now_year, [19:16] now_month, [24:20] now_mday, [27:25] now_weekday,
  // [32:28] now_hour, [38:33] now_minute, [44:39] now_second, [45] alarm_active,
  // [46] time_valid, [47] load_rejected
  output logic [ccal_pkg::M_DATA_W-1:0]       m_axis_tdata
);

  // Input register
  logic                         in_valid_q, in_valid_d;
  logic [ccal_pkg::OP_W-1:0]    in_op_q;
  ccal_pkg::cal_t               in_set_q;

  // Calendar state
  ccal_pkg::cal_t               cal_q, cal_d;
  logic                         alarm_q, alarm_d;
  logic                         sync_q, sync_d;
  logic [4:0]                   wake_hour_q, wake_hour_d;
  logic [5:0]                   wake_minute_q, wake_minute_d;

  // Result register
  logic                         out_valid_q, out_valid_d;
  logic                         out_rej_q, rej_d;

  logic                         in_xfer;
  logic                         advance;
  logic                         step;
  ccal_pkg::cal_t               tick_cal;
  logic                         tick_fire;
  logic                         load_ok;
  ccal_pkg::op_e                op;
  logic [4:0]                   cfg_hour;
  logic [5:0]                   cfg_minute;

  // The result register drains or is empty: the input stage may hand its item over
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign step          = in_valid_q && advance;
  assign op            = ccal_pkg::op_e'(in_op_q);

  assign in_valid_d  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = step ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the payload on each input transfer; unpack tdata, year in the lowest bits
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_op_q          <= s_axis_tuser;
      in_set_q.year    <= s_axis_tdata[15:0];
      in_set_q.month   <= s_axis_tdata[19:16];
      in_set_q.mday    <= s_axis_tdata[24:20];
      in_set_q.weekday <= s_axis_tdata[27:25];
      in_set_q.hour    <= s_axis_tdata[32:28];
      in_set_q.minute  <= s_axis_tdata[38:33];
      in_set_q.second  <= s_axis_tdata[44:39];
    end
  end

  ccal_tick u_tick (
    .cur_i         (cal_q),
    .wake_hour_i   (wake_hour_q),
    .wake_minute_i (wake_minute_q),
    .nxt_o         (tick_cal),
    .fire_o        (tick_fire)
  );

  ccal_load_chk u_load_chk (
    .set_i (in_set_q),
    .ok_o  (load_ok)
  );

  // Apply one item to the calendar state; an unused op code leaves everything alone
  always_comb begin
    cal_d   = cal_q;
    alarm_d = alarm_q;
    sync_d  = sync_q;
    rej_d   = 1'b0;
    if (step) begin
      unique case (op)
        ccal_pkg::OP_TICK: begin
          cal_d   = tick_cal;
          alarm_d = alarm_q || tick_fire;
        end
        ccal_pkg::OP_LOAD: begin
          // A rejected load keeps the time but drops the synced flag
          if (load_ok) begin
            cal_d = in_set_q;
          end
          sync_d = load_ok;
          rej_d  = !load_ok;
        end
        ccal_pkg::OP_CLEAR: begin
          alarm_d = 1'b0;
        end
        default: begin
          cal_d = cal_q;
        end
      endcase
    end
  end

  // Wake time register writes, reduced to a valid hour and minute
  assign cfg_hour   = cfg_data_i[4:0];
  assign cfg_minute = cfg_data_i[5:0];

  always_comb begin
    wake_hour_d   = wake_hour_q;
    wake_minute_d = wake_minute_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ccal_pkg::CFG_WAKE_HOUR: begin
          wake_hour_d = (cfg_hour >= ccal_pkg::HOURS_PER_DAY) ?
                        cfg_hour - ccal_pkg::HOURS_PER_DAY : cfg_hour;
        end
        ccal_pkg::CFG_WAKE_MINUTE: begin
          wake_minute_d = (cfg_minute >= ccal_pkg::MINS_PER_HOUR) ?
                          cfg_minute - ccal_pkg::MINS_PER_HOUR : cfg_minute;
        end
        default: begin
          wake_hour_d = wake_hour_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.year    <= ccal_pkg::RST_YEAR;
      cal_q.month   <= ccal_pkg::RST_MONTH;
      cal_q.mday    <= ccal_pkg::RST_MDAY;
      cal_q.weekday <= ccal_pkg::RST_WEEKDAY;
      cal_q.hour    <= 5'd0;
      cal_q.minute  <= 6'd0;
      cal_q.second  <= 6'd0;
      alarm_q       <= 1'b0;
      sync_q        <= 1'b0;
      wake_hour_q   <= ccal_pkg::RST_WAKE_HOUR;
      wake_minute_q <= ccal_pkg::RST_WAKE_MINUTE;
    end else begin
      cal_q         <= cal_d;
      alarm_q       <= alarm_d;
      sync_q        <= sync_d;
      wake_hour_q   <= wake_hour_d;
      wake_minute_q <= wake_minute_d;
    end
  end

  // The result is the state after the item, so it is the state registers themselves
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_rej_q <= rej_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_rej_q, sync_q, alarm_q, cal_q.second, cal_q.minute,
                          cal_q.hour, cal_q.weekday, cal_q.mday, cal_q.month, cal_q.year};

  // State may only move when an item is handed to the result register; while a result waits,
  // the state it shows must hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Time of day stays in range whatever was loaded or ticked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cal_q.hour < ccal_pkg::HOURS_PER_DAY) && (cal_q.minute < ccal_pkg::MINS_PER_HOUR) &&
    (cal_q.second < ccal_pkg::SECS_PER_MIN) && (cal_q.weekday <= ccal_pkg::LAST_WEEKDAY))
    else $error("calendar time out of range");

  // A rejected load never reports a synced time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_rej_q && sync_q))
    else $error("rejected load reported as synced");

  // An alarm clear leaves the alarm low in its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (op == ccal_pkg::OP_CLEAR)) |=> !alarm_q)
    else $error("alarm clear had no effect");

  // Input back-pressure only when both stages are full and the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without cause");

endmodule

[dv/clock_face_checker.sv]
module clock_face_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ccal_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ccal_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  // [15:0] set_year, [19:16] set_month, [24:20] set_mday, [27:25] set_weekday,
  // [32:28] set_hour, [38:33] set_minute, [44:39] set_second, [47:45] zero
  input  logic [ccal_pkg::S_DATA_W-1:0]       s_axis_tdata,
  // [1:0] op
  input  logic [ccal_pkg::OP_W-1:0]           s_axis_tuser,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] now_year, [19:16] now_month, [24:20] now_mday, [27:25] now_weekday,
  // [32:28] now_hour, [38:33] now_minute, [44:39] now_second, [45] alarm_active,
  // [46] time_valid, [47] load_rejected
  input  logic [ccal_pkg::M_DATA_W-1:0]       m_axis_tdata,
  output int                                  fail_count_o,
  output int                                  pending_o
);

  import ccal_pkg::*;

  // Same layout as the result bus; the low 45 bits also match the input bus
  typedef struct packed {
    logic       rejected;
    logic       synced;
    logic       alarm;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [4:0] mday;
    logic [3:0] month;
    logic [15:0] year;
  } clock_face_t;

  clock_face_t now_face;
  clock_face_t req_face;
  clock_face_t got_face;
  clock_face_t want_face;
  clock_face_t expected_faces[$];
  logic [4:0]  wake_hr;
  logic [5:0]  wake_min;
  int          fails;

  function automatic bit leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    int unsigned len;
    case (m)
      4, 6, 9, 11: len = 30;
      2:           len = leap_year(y) ? 29 : 28;
      default:     len = 31;
    endcase
    return len;
  endfunction

  function automatic void apply_tick();
    int unsigned sec, mins, hrs, day, mon, now_s, wake_s;
    sec  = now_face.second;
    mins = now_face.minute;
    hrs  = now_face.hour;
    sec++;
    if (sec >= 60) begin
      sec = 0;
      mins++;
      if (mins >= 60) begin
        mins = 0;
        hrs++;
        if (hrs >= 24) begin
          // midnight: roll the calendar by one day
          hrs = 0;
          now_face.weekday = 3'((now_face.weekday + 1) % 7);
          day = now_face.mday + 1;
          if (day > month_days(now_face.year, now_face.month)) begin
            day = 1;
            mon = now_face.month + 1;
            if (mon > 12) begin
              mon = 1;
              now_face.year = now_face.year + 16'd1;
            end
            now_face.month = 4'(mon);
          end
          now_face.mday = 5'(day);
        end
      end
    end
    now_face.second = 6'(sec);
    now_face.minute = 6'(mins);
    now_face.hour   = 5'(hrs);
    now_s  = hrs * 3600 + mins * 60 + sec;
    wake_s = wake_hr * 3600 + wake_min * 60;
    if (now_s >= wake_s) now_face.alarm = 1'b1;
  endfunction

  function automatic bit apply_load(input clock_face_t req);
    if (req.year < YEAR_MIN || req.month == 0 || req.month > 12 || req.weekday > 6 ||
        req.mday == 0 || req.mday > month_days(req.year, req.month) ||
        req.hour >= 24 || req.minute >= 60 || req.second >= 60) begin
      now_face.synced = 1'b0;
      return 1'b0;
    end
    now_face.year    = req.year;
    now_face.month   = req.month;
    now_face.mday    = req.mday;
    now_face.weekday = req.weekday;
    now_face.hour    = req.hour;
    now_face.minute  = req.minute;
    now_face.second  = req.second;
    now_face.synced  = 1'b1;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v) begin
      fails++;
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_face         = '0;
      now_face.year    = RST_YEAR;
      now_face.month   = RST_MONTH;
      now_face.mday    = RST_MDAY;
      now_face.weekday = RST_WEEKDAY;
      wake_hr          = RST_WAKE_HOUR;
      wake_min         = RST_WAKE_MINUTE;
      expected_faces.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WAKE_HOUR) wake_hr = 5'(cfg_data_i[4:0] % 24);
        else wake_min = 6'(cfg_data_i[5:0] % 60);
      end
      // Retire the oldest expectation first so a new push never masks a stray result
      if (m_axis_tvalid && m_axis_tready) begin
        got_face = clock_face_t'(m_axis_tdata);
        if (expected_faces.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected: expected none, actual %h",
                   $time, m_axis_tdata);
        end else begin
          want_face = expected_faces.pop_front();
          check_field("now_year", want_face.year, got_face.year);
          check_field("now_month", want_face.month, got_face.month);
          check_field("now_mday", want_face.mday, got_face.mday);
          check_field("now_weekday", want_face.weekday, got_face.weekday);
          check_field("now_hour", want_face.hour, got_face.hour);
          check_field("now_minute", want_face.minute, got_face.minute);
          check_field("now_second", want_face.second, got_face.second);
          check_field("alarm_active", want_face.alarm, got_face.alarm);
          check_field("time_valid", want_face.synced, got_face.synced);
          check_field("load_rejected", want_face.rejected, got_face.rejected);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req_face = clock_face_t'(s_axis_tdata);
        now_face.rejected = 1'b0;
        case (s_axis_tuser)
          OP_TICK:  apply_tick();
          OP_LOAD:  now_face.rejected = !apply_load(req_face);
          OP_CLEAR: now_face.alarm = 1'b0;
          default:  ;
        endcase
        expected_faces.push_back(now_face);
      end
      fail_count_o <= fails;
      pending_o    <= expected_faces.size();
    end
  end

endmodule

[dv/testbench.sv]
module testbench;

  import ccal_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 3;
  // Longest stretch with no transfer; must exceed the longest sender gap or sink stall
  localparam int WATCHDOG_LIMIT  = 2000;
  // Two-stage pipeline; spare settling time before the verdict
  localparam int SETTLE_CYCLES   = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int NUM_PHASES      = 7;
  // Op code that the block must pass through without any change
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic [OP_W-1:0]       s_axis_tuser  = '0;
  logic                  m_axis_tready = 1'b0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [M_DATA_W-1:0]   m_axis_tdata;

  int   fail_count;
  int   pending;
  int   sent_items  = 0;
  int   idle_cycles = 0;
  // Set to turn off idling on both sides for a whole phase
  bit   steady_flow = 1'b0;
  // Wake time as the block holds it, used to aim loads just short of the alarm
  int unsigned wake_h_now = 0;
  int unsigned wake_m_now = 1;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  calendar_clock_with_alarm dut (.*);

  clock_face_checker face_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Gap length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Pack a date and time into the input bus layout, spare top bits zero
  function automatic logic [S_DATA_W-1:0] pack_time(
    input int unsigned y, input int unsigned m, input int unsigned d, input int unsigned w,
    input int unsigned h, input int unsigned mi, input int unsigned s);
    return {3'b000, 6'(s), 6'(mi), 5'(h), 3'(w), 5'(d), 4'(m), 16'(y)};
  endfunction

  // Present one item, hold it until the block takes the transfer
  task automatic send(input logic [OP_W-1:0] op, input logic [S_DATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
  endtask

  // Tick with junk in the data fields, which a tick must ignore
  task automatic send_tick();
    send(OP_TICK, {3'b000, 13'($urandom), 32'($urandom)});
  endtask

  task automatic send_load(input int unsigned y, input int unsigned m, input int unsigned d,
                           input int unsigned w, input int unsigned h, input int unsigned mi,
                           input int unsigned s);
    send(OP_LOAD, pack_time(y, m, d, w, h, mi, s));
  endtask

  // Drop valid and hold until every expected result has been checked
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Write both alarm registers back to back; only call with the block idle
  task automatic set_wake(input int unsigned h, input int unsigned m);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WAKE_HOUR;
    cfg_data_i <= 6'(h);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_WAKE_MINUTE;
    cfg_data_i <= 6'(m);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    wake_h_now = (h % 32) % 24;
    wake_m_now = (m % 64) % 60;
  endtask

  // Load a valid-looking date, often close to a rollover or the alarm, then run the clock with some clears
  task automatic boundary_burst();
    int unsigned y, m, d, w, h, mi, s, r, burst;
    case ($urandom_range(0, 7))
      0:       y = 2000;
      1:       y = 2100;
      2:       y = 2400;
      3:       y = 2024;
      4:       y = 65535;
      5:       y = $urandom_range(2000, 2099);
      default: y = $urandom_range(2000, 65535);
    endcase
    r = $urandom_range(0, 9);
    if (r < 3) m = 2;
    else if (r < 5) m = 12;
    else m = $urandom_range(1, 12);
    // End-of-month days are sometimes out of range and get rejected
    d = ($urandom_range(0, 1) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 28);
    w = $urandom_range(0, 6);
    r = $urandom_range(0, 9);
    if (r < 4) begin
      h  = 23;
      mi = 59;
      s  = $urandom_range(40, 59);
    end else if (r < 7) begin
      h  = wake_h_now;
      mi = (wake_m_now > 0) ? wake_m_now - 1 : 0;
      s  = $urandom_range(40, 59);
    end else begin
      h  = $urandom_range(0, 23);
      mi = $urandom_range(0, 59);
      s  = $urandom_range(0, 59);
    end
    send_load(y, m, d, w, h, mi, s);
    burst = $urandom_range(1, 70);
    repeat (burst) begin
      if ($urandom_range(0, 99) < 3) send(OP_CLEAR, '0);
      else send_tick();
    end
  endtask

  // Sink: stall at random, with a few long stalls
  initial begin
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  // Watchdog: end the run when transfers stop for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned hour_set [NUM_PHASES];
    int unsigned min_set [NUM_PHASES];
    int          phase_end;
    int          r;
    bit          mid_hold_done;

    mid_hold_done = 1'b0;
    // Wake settings per phase: defaults, extremes, masked and out-of-range values
    hour_set = '{0, 23, 0, 63, 12, 24, 0};
    min_set  = '{1, 59, 0, 63, 30, 60, 0};
    hour_set[NUM_PHASES-1] = $urandom_range(0, 63);
    min_set[NUM_PHASES-1]  = $urandom_range(0, 63);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset wake time of 00:01
    send_tick();
    send(OP_UNUSED, pack_time(65535, 15, 31, 7, 31, 63, 63));
    // all fields at their lowest, then at their highest: both rejected
    send_load(0, 0, 0, 0, 0, 0, 0);
    send_load(65535, 15, 31, 7, 31, 63, 63);
    // year just below the floor
    send_load(1999, 12, 31, 5, 23, 59, 59);
    // leap day in a year divisible by 400, then roll into March
    send_load(2000, 2, 29, 2, 23, 59, 59);
    send_tick();
    // century year that is not a leap year
    send_load(2100, 2, 29, 1, 12, 0, 0);
    send_load(2100, 2, 28, 0, 23, 59, 59);
    send_tick();
    // ordinary leap year: February 28 rolls to the 29th
    send_load(2024, 2, 28, 3, 23, 59, 59);
    send_tick();
    // day past the end of a 30-day month
    send_load(2023, 4, 31, 1, 10, 0, 0);
    // year end without wrap, then the 16-bit year wrap
    send_load(2023, 12, 31, 0, 23, 59, 59);
    send_tick();
    send_load(65535, 12, 31, 6, 23, 59, 59);
    send_tick();
    // bad weekday, hour, minute and second, one at a time
    send_load(2001, 1, 1, 7, 0, 0, 0);
    send_load(2001, 1, 1, 1, 24, 0, 0);
    send_load(2001, 1, 1, 1, 0, 60, 0);
    send_load(2001, 1, 1, 1, 0, 0, 60);
    // reach the alarm, clear it, and see it latch again on the next tick
    send_load(2010, 6, 15, 2, 0, 0, 59);
    send_tick();
    send(OP_CLEAR, '0);
    send_tick();
    // an accepted load leaves a set alarm alone
    send_load(2010, 6, 15, 2, 0, 0, 0);

    // Random part: one phase per wake setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      set_wake(hour_set[p], min_set[p]);
      steady_flow = (p == 2);
      phase_end = sent_items + ITEMS_PER_PHASE;
      while (sent_items < phase_end) begin
        // Hold the sender once, midway through phase 4, until the pipeline has emptied
        if (p == 4 && !mid_hold_done && sent_items >= phase_end - ITEMS_PER_PHASE / 2) begin
          wait_idle();
          mid_hold_done = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
          boundary_burst();
        end else if (r < 85) begin
          // malformed load with fully random fields, then a few ticks
          send_load($urandom_range(0, 65535), $urandom_range(0, 15), $urandom_range(0, 31),
                    $urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 63),
                    $urandom_range(0, 63));
          repeat ($urandom_range(1, 5)) send_tick();
        end else if (r < 93) begin
          send(OP_CLEAR, {3'b000, 13'($urandom), 32'($urandom)});
        end else if (r < 97) begin
          send(OP_UNUSED, {3'b000, 13'($urandom), 32'($urandom)});
        end else begin
          repeat ($urandom_range(1, 10)) send_tick();
        end
      end
    end
    steady_flow = 1'b0;

    // Drain, let the pipeline settle, then give the verdict
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ccal_pkg.sv
rtl/ccal_tick.sv
rtl/ccal_load_chk.sv
rtl/calendar_clock_with_alarm.sv
dv/clock_face_checker.sv
dv/testbench.sv
